// ----- sv/edfs_pkg.sv -----
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared sizes, codes and controller/datapath handshake types for the
// earliest-deadline-first scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

	// table sizes
	localparam int MAX_TASKS = 64;
	localparam int MAX_CORES = 8;
	localparam int DL_W      = 32;

	// port widths
	localparam int CMD_W      = 2;
	localparam int ID_W       = 6;
	localparam int DLIN_W     = 32;
	localparam int CORE_OUT_W = 3;
	localparam int FIN_OUT_W  = 7;
	localparam int SW_W       = 32;
	localparam int ACT_W      = 4;

	// derived internal widths
	localparam int TASK_AW  = $clog2(MAX_TASKS);
	localparam int CORE_W   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NC_W     = $clog2(MAX_CORES + 1);
	localparam int SCAN_LEN = (MAX_TASKS > MAX_CORES) ? MAX_TASKS : MAX_CORES;
	localparam int CNT_W    = $clog2(SCAN_LEN);
	localparam int FIN_W    = $clog2(MAX_TASKS + 1);

	localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(8);

	typedef enum logic [CMD_W-1:0] {
		CMD_ARRIVE = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_PASS   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVENT,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic load;      // capture the incoming event
		logic apply;     // update task and core flags for the event
		logic scan_clr;  // restart the table scan
		logic issue;     // issue one table read
		logic commit;    // dispatch/preempt and load the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic slot_free;
	} dp_sts_t;

endpackage

// ----- sv/edf_multicore_scheduler.sv -----
// ----------------------------------------------------------------------------
// edf_multicore_scheduler
// Preemptive earliest-deadline-first scheduler over a task table and cores.
// ----------------------------------------------------------------------------
// Usage:
//   Events (cmd, task_id, deadline) enter on the in_valid/in_ready channel;
//   one result per event leaves on out_valid/out_ready. A transfer happens
//   on a rising edge with valid and ready both high.
//   cfg_we writes the active core count from cfg_wdata; write it only while
//   no event is in flight.
//   An event passes through the flag update, the deadline table scan, a
//   drain state and the decision before its result is registered; the
//   next event is taken only once that decision is made. The scan reads
//   the single-read-port deadline RAM once per cycle; the core scan runs
//   alongside it.
//   A finished result sits in the output register; if the receiver stalls,
//   the next event is still taken and worked on, and its decision waits
//   until the output register frees up.
//   Reset clears all task and core flags, the counters and both valids, and
//   sets the active core count to 8. The deadline table needs no clearing.
// ----------------------------------------------------------------------------
module edf_multicore_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [edfs_pkg::ACT_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [edfs_pkg::CMD_W-1:0]          cmd,
	input  logic [edfs_pkg::ID_W-1:0]           task_id,
	input  logic [edfs_pkg::DLIN_W-1:0]         deadline,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                dispatched,
	output logic [edfs_pkg::ID_W-1:0]           dispatch_task,
	output logic [edfs_pkg::CORE_OUT_W-1:0]     dispatch_core,
	output logic                                preempted,
	output logic [edfs_pkg::ID_W-1:0]           preempted_task,
	output logic [edfs_pkg::FIN_OUT_W-1:0]      finished_count,
	output logic [edfs_pkg::SW_W-1:0]           switch_count,
	output logic                                bad_event
);
	import edfs_pkg::*;

	ctrl_cmd_t ctl;
	dp_sts_t   sts;

	edfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (ctl)
	);

	edfs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd_in         (cmd),
		.task_id        (task_id),
		.deadline       (deadline),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.dispatched     (dispatched),
		.dispatch_task  (dispatch_task),
		.dispatch_core  (dispatch_core),
		.preempted      (preempted),
		.preempted_task (preempted_task),
		.finished_count (finished_count),
		.switch_count   (switch_count),
		.bad_event      (bad_event)
	);

	// one event in flight at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an event is in flight");

	a_preempt_dispatches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && preempted |-> dispatched)
		else $error("preemption without a dispatch");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dispatched |-> (dispatch_task == '0 && dispatch_core == '0))
		else $error("dispatch fields set without a dispatch");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> sts.slot_free)
		else $error("result committed over an unread result");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.commit))
		else $error("result appeared without a commit");

endmodule

// ----- sv/edfs_ram.sv -----
// ----------------------------------------------------------------------------
// edfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/edfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// edfs_ctrl
// Sequencer for one scheduling event: flag update, table scan, decision.
// ----------------------------------------------------------------------------
module edfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  edfs_pkg::dp_sts_t   sts,
	output edfs_pkg::ctrl_cmd_t cmd
);
	import edfs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVENT;
			end
			ST_EVENT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				// hold until the result register can take the new result
				if (sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVENT: begin
				cmd.apply    = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			ST_SCAN:   cmd.issue  = 1'b1;
			ST_DRAIN:  ;
			ST_DECIDE: cmd.commit = sts.slot_free;
			default:   ;
		endcase
	end

endmodule

// ----- sv/edfs_dp.sv -----
// ----------------------------------------------------------------------------
// edfs_dp
// Scheduler datapath: task and core state, deadline table, min/max scan
// and the result register.
// ----------------------------------------------------------------------------
module edfs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  edfs_pkg::ctrl_cmd_t                 cmd,
	output edfs_pkg::dp_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [edfs_pkg::ACT_W-1:0]          cfg_wdata,
	input  logic [edfs_pkg::CMD_W-1:0]          cmd_in,
	input  logic [edfs_pkg::ID_W-1:0]           task_id,
	input  logic [edfs_pkg::DLIN_W-1:0]         deadline,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                dispatched,
	output logic [edfs_pkg::ID_W-1:0]           dispatch_task,
	output logic [edfs_pkg::CORE_OUT_W-1:0]     dispatch_core,
	output logic                                preempted,
	output logic [edfs_pkg::ID_W-1:0]           preempted_task,
	output logic [edfs_pkg::FIN_OUT_W-1:0]      finished_count,
	output logic [edfs_pkg::SW_W-1:0]           switch_count,
	output logic                                bad_event
);
	import edfs_pkg::*;

	// configuration
	logic [ACT_W-1:0] active_q;
	logic [NC_W-1:0]  ncores;

	// captured event
	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [DL_W-1:0]  dl_q;
	logic             bad_q;

	// task and core state
	logic [MAX_TASKS-1:0] arrived_q, running_q, done_q;
	logic [MAX_CORES-1:0] busy_q;
	logic [TASK_AW-1:0]   core_task_q [MAX_CORES];
	logic [DL_W-1:0]      core_dl_q   [MAX_CORES];
	logic [FIN_W-1:0]     fin_cnt_q;
	logic [SW_W-1:0]      sw_cnt_q;

	// scan
	logic [CNT_W-1:0]   cnt_q;
	logic               valid_s1;
	logic [CNT_W-1:0]   idx_s1;
	logic [DL_W-1:0]    rd_dl;
	logic               found_q, free_found_q;
	logic [TASK_AW-1:0] sel_q;
	logic [DL_W-1:0]    best_dl_q, worst_dl_q;
	logic [CORE_W-1:0]  free_core_q, vic_q;

	// result register
	logic                  out_valid_q;
	logic                  dispatched_q, preempted_q, bad_out_q;
	logic [ID_W-1:0]       dtask_q, ptask_q;
	logic [CORE_OUT_W-1:0] dcore_q;
	logic [FIN_OUT_W-1:0]  fin_out_q;
	logic [SW_W-1:0]       sw_out_q;

	// event decode
	logic [TASK_AW-1:0] id_ix;
	logic               id_ok, arrive_ok, finish_ok, ev_bad;

	// scan step
	logic [TASK_AW-1:0] jt;
	logic [CORE_W-1:0]  jc;
	logic               task_ok, core_ok, task_hit, free_hit, worst_hit;

	// decision
	logic               do_pre, do_disp;
	logic [CORE_W-1:0]  disp_core;
	logic [TASK_AW-1:0] vic_task;

	// active core count, 0 as 1 and clipped to the core count
	always_comb begin
		if (active_q == '0) begin
			ncores = NC_W'(1);
		end else if (32'(active_q) > MAX_CORES) begin
			ncores = NC_W'(MAX_CORES);
		end else begin
			ncores = NC_W'(active_q);
		end
	end

	always_comb begin
		id_ix     = TASK_AW'(id_q);
		id_ok     = 32'(id_q) < 32'(MAX_TASKS);
		arrive_ok = 1'b0;
		finish_ok = 1'b0;
		ev_bad    = 1'b0;
		case (cmd_q)
			CMD_ARRIVE: begin
				arrive_ok = id_ok && !arrived_q[id_ix];
				ev_bad    = !arrive_ok;
			end
			CMD_FINISH: begin
				finish_ok = id_ok && running_q[id_ix];
				ev_bad    = !finish_ok;
			end
			default: ;
		endcase
	end

	edfs_ram #(
		.WIDTH (DL_W),
		.DEPTH (MAX_TASKS)
	) u_dl_ram (
		.clk   (clk),
		.we    (cmd.apply && arrive_ok),
		.waddr (id_ix),
		.wdata (dl_q),
		.re    (cmd.issue),
		.raddr (TASK_AW'(cnt_q)),
		.rdata (rd_dl)
	);

	always_comb begin
		jt        = TASK_AW'(idx_s1);
		jc        = CORE_W'(idx_s1);
		task_ok   = 32'(idx_s1) < 32'(MAX_TASKS);
		core_ok   = 32'(idx_s1) < 32'(ncores);
		task_hit  = valid_s1 && task_ok && arrived_q[jt] && !running_q[jt] && !done_q[jt]
		            && (!found_q || (rd_dl < best_dl_q));
		free_hit  = valid_s1 && core_ok && !busy_q[jc] && !free_found_q;
		// latest running deadline, lowest core on a tie
		worst_hit = valid_s1 && core_ok && ((idx_s1 == '0) || (worst_dl_q < core_dl_q[jc]));
	end

	always_comb begin
		vic_task  = core_task_q[vic_q];
		do_pre    = found_q && !free_found_q && (best_dl_q < worst_dl_q);
		do_disp   = found_q && (free_found_q || do_pre);
		disp_core = free_found_q ? free_core_q : vic_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= ACTIVE_RESET;
			arrived_q    <= '0;
			running_q    <= '0;
			done_q       <= '0;
			busy_q       <= '0;
			fin_cnt_q    <= '0;
			sw_cnt_q     <= '0;
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) active_q <= cfg_wdata;

			if (cmd.apply) begin
				if (arrive_ok) arrived_q[id_ix] <= 1'b1;
				if (finish_ok) begin
					running_q[id_ix] <= 1'b0;
					done_q[id_ix]    <= 1'b1;
					fin_cnt_q        <= fin_cnt_q + FIN_W'(1);
					for (int c = 0; c < MAX_CORES; c++) begin
						if (busy_q[c] && core_task_q[c] == id_ix) busy_q[c] <= 1'b0;
					end
				end
			end

			if (cmd.scan_clr) begin
				cnt_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			valid_s1 <= cmd.issue;
			if (task_hit) found_q      <= 1'b1;
			if (free_hit) free_found_q <= 1'b1;

			if (cmd.commit) begin
				// a preempted core is refilled at once, so it stays busy
				if (do_pre) begin
					running_q[vic_task] <= 1'b0;
					sw_cnt_q            <= sw_cnt_q + SW_W'(1);
				end
				if (do_disp) begin
					busy_q[disp_core] <= 1'b1;
					running_q[sel_q]  <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_in;
			id_q  <= task_id;
			dl_q  <= DL_W'(deadline);
		end
		if (cmd.apply) bad_q <= ev_bad;

		idx_s1 <= cnt_q;
		if (task_hit) begin
			sel_q     <= jt;
			best_dl_q <= rd_dl;
		end
		if (free_hit) free_core_q <= jc;
		if (worst_hit) begin
			worst_dl_q <= core_dl_q[jc];
			vic_q      <= jc;
		end

		if (cmd.commit) begin
			if (do_disp) begin
				core_task_q[disp_core] <= sel_q;
				core_dl_q[disp_core]   <= best_dl_q;
			end
			dispatched_q <= do_disp;
			dtask_q      <= do_disp ? ID_W'(sel_q) : '0;
			dcore_q      <= do_disp ? CORE_OUT_W'(disp_core) : '0;
			preempted_q  <= do_pre;
			ptask_q      <= do_pre ? ID_W'(vic_task) : '0;
			fin_out_q    <= FIN_OUT_W'(fin_cnt_q);
			sw_out_q     <= do_pre ? sw_cnt_q + SW_W'(1) : sw_cnt_q;
			bad_out_q    <= bad_q;
		end
	end

	assign sts.scan_last = (cnt_q == CNT_W'(SCAN_LEN - 1));
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign dispatched     = dispatched_q;
	assign dispatch_task  = dtask_q;
	assign dispatch_core  = dcore_q;
	assign preempted      = preempted_q;
	assign preempted_task = ptask_q;
	assign finished_count = fin_out_q;
	assign switch_count   = sw_out_q;
	assign bad_event      = bad_out_q;

endmodule
